// ===== rtl/ric_pkg.sv =====
package ric_pkg;

    localparam int HOLD_W = 20;
    localparam int CNT_W  = HOLD_W + 1;
    localparam int REQ_W  = 3;
    localparam int OUT_W  = 3;
    localparam int IDX_W  = 8;

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(30000);

    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUMP   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FAN    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_HEATER = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIGHTS = 3'd4;

    localparam logic [OUT_W-1:0] OUT_TICK      = 3'd0;
    localparam logic [OUT_W-1:0] OUT_APPLIED   = 3'd1;
    localparam logic [OUT_W-1:0] OUT_SAME      = 3'd2;
    localparam logic [OUT_W-1:0] OUT_HELD      = 3'd3;
    localparam logic [OUT_W-1:0] OUT_INTERLOCK = 3'd4;

    localparam logic [IDX_W-1:0] CFG_HOLD_MS     = 8'd0;
    localparam logic [IDX_W-1:0] CFG_MANUAL_MODE = 8'd1;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ms;
        logic              manual_mode;
    } t_cfg;

    typedef struct packed {
        logic pump;
        logic fan;
        logic heater;
        logic lights;
    } t_levels;

endpackage

// ===== rtl/ric_cfg_regs.sv =====
module ric_cfg_regs
    import ric_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [HOLD_W-1:0] i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ms     <= HOLD_RESET;
            r_cfg.manual_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_HOLD_MS) begin
                r_cfg.hold_ms <= i_cfg_data;
            end else if (i_cfg_index == CFG_MANUAL_MODE) begin
                r_cfg.manual_mode <= i_cfg_data[0];
            end
        end
    end

endmodule

// ===== rtl/ric_core.sv =====
module ric_core
    import ric_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic             i_command_on,
    input  t_cfg             i_cfg,
    output t_levels          o_levels,
    output logic [OUT_W-1:0] o_outcome
);

    t_levels          r_lvl;
    t_levels          n_lvl;
    logic [CNT_W-1:0] r_fan_hold;
    logic [CNT_W-1:0] r_heater_hold;
    logic [CNT_W-1:0] r_lights_hold;
    logic [CNT_W-1:0] n_fan_hold;
    logic [CNT_W-1:0] n_heater_hold;
    logic [CNT_W-1:0] n_lights_hold;
    logic [OUT_W-1:0] outcome;
    logic [CNT_W-1:0] reload_val;
    logic             man;

    assign man        = i_cfg.manual_mode;
    assign reload_val = {1'b0, i_cfg.hold_ms} + CNT_W'(1);

    always_comb begin
        n_lvl         = r_lvl;
        n_fan_hold    = r_fan_hold;
        n_heater_hold = r_heater_hold;
        n_lights_hold = r_lights_hold;
        outcome       = OUT_TICK;
        unique case (i_req_type)
            REQ_TICK: begin
                if (r_fan_hold != '0) n_fan_hold = r_fan_hold - CNT_W'(1);
                if (r_heater_hold != '0) n_heater_hold = r_heater_hold - CNT_W'(1);
                if (r_lights_hold != '0) n_lights_hold = r_lights_hold - CNT_W'(1);
            end
            REQ_PUMP: begin
                if (i_command_on == r_lvl.pump) begin
                    outcome = OUT_SAME;
                end else begin
                    n_lvl.pump = i_command_on;
                    outcome    = OUT_APPLIED;
                end
            end
            REQ_FAN: begin
                if (r_fan_hold != '0 && !man) begin
                    outcome = OUT_HELD;
                end else if (i_command_on == r_lvl.fan) begin
                    outcome = OUT_SAME;
                end else if (!i_command_on && r_lvl.heater) begin
                    outcome = OUT_INTERLOCK;
                end else begin
                    n_lvl.fan = i_command_on;
                    if (!man) n_fan_hold = reload_val;
                    outcome = OUT_APPLIED;
                end
            end
            REQ_HEATER: begin
                if (r_heater_hold != '0 && !man) begin
                    outcome = OUT_HELD;
                end else begin
                    if (i_command_on) n_lvl.fan = 1'b1;
                    if (i_command_on == r_lvl.heater) begin
                        outcome = OUT_SAME;
                    end else begin
                        n_lvl.heater = i_command_on;
                        if (!man) n_heater_hold = reload_val;
                        outcome = OUT_APPLIED;
                    end
                end
            end
            REQ_LIGHTS: begin
                if (r_lights_hold != '0 && !man) begin
                    outcome = OUT_HELD;
                end else if (i_command_on == r_lvl.lights) begin
                    outcome = OUT_SAME;
                end else begin
                    n_lvl.lights = i_command_on;
                    if (!man) n_lights_hold = reload_val;
                    outcome = OUT_APPLIED;
                end
            end
            default: begin
                outcome = OUT_TICK;
            end
        endcase
    end

    assign o_levels  = n_lvl;
    assign o_outcome = outcome;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl         <= '0;
            r_fan_hold    <= '0;
            r_heater_hold <= '0;
            r_lights_hold <= '0;
        end else if (i_en) begin
            r_lvl         <= n_lvl;
            r_fan_hold    <= n_fan_hold;
            r_heater_hold <= n_heater_hold;
            r_lights_hold <= n_lights_hold;
        end
    end

endmodule

// ===== rtl/relay_interlock_hold_controller.sv =====
// Path: input register, one update stage, result register; a request moves on only when
// the result register is free. Throughput: one request per cycle unless stalled.
// The result register frees itself in the cycle the downstream side takes it.
// Reset (synchronous, active low) clears the hold counters and turns all actuators off
// in the core (not in the result register), sets hold time 30000 ticks, manual mode off.
module relay_interlock_hold_controller
    import ric_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic              i_command_on,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_pump_on,
    output logic              o_fan_on,
    output logic              o_heater_on,
    output logic              o_lights_on,
    output logic [OUT_W-1:0]  o_outcome,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [HOLD_W-1:0] i_cfg_data
);

    t_cfg             cfg;
    t_levels          lvl;
    logic [OUT_W-1:0] outcome;

    logic             r_in_valid;
    logic [REQ_W-1:0] r_in_req;
    logic             r_in_on;
    logic             r_out_valid;
    t_levels          r_out_lvl;
    logic [OUT_W-1:0] r_out_outcome;

    logic out_free;
    logic advance;
    logic in_accept;

    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign in_accept = i_valid && !o_stall;

    ric_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ric_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_req_type   (r_in_req),
        .i_command_on (r_in_on),
        .i_cfg        (cfg),
        .o_levels     (lvl),
        .o_outcome    (outcome)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_req <= i_req_type;
            r_in_on  <= i_command_on;
        end
        if (advance) begin
            r_out_lvl     <= lvl;
            r_out_outcome <= outcome;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pump_on   = r_out_lvl.pump;
    assign o_fan_on    = r_out_lvl.fan;
    assign o_heater_on = r_out_lvl.heater;
    assign o_lights_on = r_out_lvl.lights;
    assign o_outcome   = r_out_outcome;

endmodule

// ===== dv/relay_checker.sv =====
`timescale 1ns / 1ps

module relay_checker
    import ric_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic              i_command_on,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic              i_pump_on,
    input  logic              i_fan_on,
    input  logic              i_heater_on,
    input  logic              i_lights_on,
    input  logic [OUT_W-1:0]  i_outcome,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [HOLD_W-1:0] i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        t_levels          levels;
        logic [OUT_W-1:0] outcome;
    } t_relay_result;

    t_cfg             cfg;
    t_levels          levels;
    logic [CNT_W-1:0] fan_left;
    logic [CNT_W-1:0] heater_left;
    logic [CNT_W-1:0] lights_left;
    t_relay_result    expected_results[$];
    int               errors = 0;

    function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] left);
        return (left != '0) ? left - 1'b1 : '0;
    endfunction

    function automatic logic may_change(input logic [CNT_W-1:0] left);
        return (left == '0) || cfg.manual_mode;
    endfunction

    function automatic logic [CNT_W-1:0] reload_value(input logic [CNT_W-1:0] left);
        return cfg.manual_mode ? left : CNT_W'(cfg.hold_ms) + 1'b1;
    endfunction

    function automatic t_relay_result apply_request(input logic [REQ_W-1:0] req,
                                                    input logic on);
        t_relay_result r;
        r.outcome = OUT_TICK;
        case (req)
            REQ_TICK: begin
                fan_left    = count_down(fan_left);
                heater_left = count_down(heater_left);
                lights_left = count_down(lights_left);
            end
            REQ_PUMP: begin
                if (on == levels.pump) begin
                    r.outcome = OUT_SAME;
                end else begin
                    levels.pump = on;
                    r.outcome   = OUT_APPLIED;
                end
            end
            REQ_FAN: begin
                if (!may_change(fan_left)) begin
                    r.outcome = OUT_HELD;
                end else if (on == levels.fan) begin
                    r.outcome = OUT_SAME;
                end else if (!on && levels.heater) begin
                    r.outcome = OUT_INTERLOCK;
                end else begin
                    levels.fan = on;
                    fan_left   = reload_value(fan_left);
                    r.outcome  = OUT_APPLIED;
                end
            end
            REQ_HEATER: begin
                if (!may_change(heater_left)) begin
                    r.outcome = OUT_HELD;
                end else begin
                    if (on) begin
                        levels.fan = 1'b1;
                    end
                    if (on == levels.heater) begin
                        r.outcome = OUT_SAME;
                    end else begin
                        levels.heater = on;
                        heater_left   = reload_value(heater_left);
                        r.outcome     = OUT_APPLIED;
                    end
                end
            end
            REQ_LIGHTS: begin
                if (!may_change(lights_left)) begin
                    r.outcome = OUT_HELD;
                end else if (on == levels.lights) begin
                    r.outcome = OUT_SAME;
                end else begin
                    levels.lights = on;
                    lights_left   = reload_value(lights_left);
                    r.outcome     = OUT_APPLIED;
                end
            end
            default: begin
            end
        endcase
        r.levels = levels;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_relay_result got;
        t_relay_result want;
        if (!i_rst_n) begin
            cfg.hold_ms     = HOLD_RESET;
            cfg.manual_mode = 1'b0;
            levels          = '0;
            fan_left        = '0;
            heater_left     = '0;
            lights_left     = '0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_HOLD_MS) begin
                    cfg.hold_ms = i_cfg_data;
                end else if (i_cfg_index == CFG_MANUAL_MODE) begin
                    cfg.manual_mode = i_cfg_data[0];
                end
            end
            if (i_res_valid && !i_res_stall) begin
                got.levels.pump   = i_pump_on;
                got.levels.fan    = i_fan_on;
                got.levels.heater = i_heater_on;
                got.levels.lights = i_lights_on;
                got.outcome       = i_outcome;
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: result with no request outstanding:", $time);
                        $display("%0t:   pump %0d fan %0d heater %0d lights %0d outcome %0d",
                                 $time, got.levels.pump, got.levels.fan,
                                 got.levels.heater, got.levels.lights, got.outcome);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.levels !== want.levels || got.outcome !== want.outcome) begin
                        errors++;
                        if (errors <= 10) begin
                            $display({"%0t: mismatch, expected pump %0d fan %0d heater %0d",
                                      " lights %0d outcome %0d"},
                                     $time, want.levels.pump, want.levels.fan,
                                     want.levels.heater, want.levels.lights, want.outcome);
                            $display({"%0t:           actual   pump %0d fan %0d heater %0d",
                                      " lights %0d outcome %0d"},
                                     $time, got.levels.pump, got.levels.fan,
                                     got.levels.heater, got.levels.lights, got.outcome);
                        end
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_results.push_back(apply_request(i_req_type, i_command_on));
            end
            o_pending <= expected_results.size();
        end
        o_errors <= errors;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ric_pkg::*;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_stall;
    logic [REQ_W-1:0]  req_type   = REQ_TICK;
    logic              command_on = 1'b0;
    logic              res_valid;
    logic              res_stall  = 1'b0;
    logic              pump_on;
    logic              fan_on;
    logic              heater_on;
    logic              lights_on;
    logic [OUT_W-1:0]  outcome;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index  = CFG_HOLD_MS;
    logic [HOLD_W-1:0] cfg_data   = '0;

    int errors;
    int pending;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_off_cycles = 0;
    bit hold_off_go     = 1'b0;

    relay_interlock_hold_controller dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_req_type   (req_type),
        .i_command_on (command_on),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_pump_on    (pump_on),
        .o_fan_on     (fan_on),
        .o_heater_on  (heater_on),
        .o_lights_on  (lights_on),
        .o_outcome    (outcome),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    relay_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req_type   (req_type),
        .i_command_on (command_on),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_pump_on    (pump_on),
        .i_fan_on     (fan_on),
        .i_heater_on  (heater_on),
        .i_lights_on  (lights_on),
        .i_outcome    (outcome),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    // The long hold-off lets the sender fill the block until it stalls its input.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_go) begin
                hold_off_go     = 1'b0;
                hold_off_cycles = 80;
            end
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic offer(input logic [REQ_W-1:0] req, input logic on);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_type   <= req;
        command_on <= on;
        do @(posedge clk); while (req_stall);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_config(input logic [HOLD_W-1:0] hold, input logic manual);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_HOLD_MS;
        cfg_data  <= hold;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_MANUAL_MODE;
        cfg_data  <= (HOLD_W'($urandom) << 1) | HOLD_W'(manual);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [HOLD_W-1:0] hold_list [8];
        logic              manual_list [8];
        int                roll;
        logic [REQ_W-1:0]  req;

        hold_list   = '{20'd0, 20'd3, 20'd1, 20'd9, 20'd2, 20'd0, 20'd5, 20'hFFFFF};
        manual_list = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        offer(REQ_TICK, 1'b0);
        offer(REQ_PUMP, 1'b1);
        offer(REQ_PUMP, 1'b1);
        offer(REQ_PUMP, 1'b0);
        offer(REQ_LIGHTS + 3'd1, 1'b0);
        offer(REQ_LIGHTS + 3'd2, 1'b1);
        offer(REQ_LIGHTS + 3'd3, 1'b1);
        offer(REQ_FAN, 1'b0);

        wait_drained();
        write_config(20'd2, 1'b0);
        offer(REQ_HEATER, 1'b1);
        offer(REQ_FAN, 1'b0);
        offer(REQ_HEATER, 1'b0);
        offer(REQ_HEATER, 1'b1);
        offer(REQ_LIGHTS, 1'b1);
        offer(REQ_TICK, 1'b1);
        offer(REQ_TICK, 1'b0);
        offer(REQ_TICK, 1'b0);
        offer(REQ_HEATER, 1'b0);
        offer(REQ_FAN, 1'b0);
        offer(REQ_FAN, 1'b1);
        offer(REQ_LIGHTS, 1'b0);

        wait_drained();
        write_config(20'd0, 1'b1);
        offer(REQ_HEATER, 1'b1);
        offer(REQ_HEATER, 1'b1);
        offer(REQ_FAN, 1'b0);
        offer(REQ_HEATER, 1'b0);

        for (int phase = 0; phase < 8; phase++) begin
            wait_drained();
            write_config(hold_list[phase], manual_list[phase]);
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                end
                1: begin
                    sender_idle_pct = 76;
                    stall_pct       = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    stall_pct       = 76;
                end
                default: begin
                    sender_idle_pct = 24;
                    stall_pct       = 24;
                end
            endcase
            if (phase == 0) begin
                hold_off_go = 1'b1;
            end
            repeat (170) begin
                roll = $urandom_range(99);
                if (roll < 35) begin
                    req = REQ_TICK;
                end else if (roll < 45) begin
                    req = REQ_PUMP;
                end else if (roll < 62) begin
                    req = REQ_FAN;
                end else if (roll < 78) begin
                    req = REQ_HEATER;
                end else if (roll < 95) begin
                    req = REQ_LIGHTS;
                end else begin
                    req = REQ_LIGHTS + REQ_W'($urandom_range(3, 1));
                end
                offer(req, 1'($urandom_range(1)));
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ric_pkg.sv
rtl/ric_cfg_regs.sv
rtl/ric_core.sv
rtl/relay_interlock_hold_controller.sv
dv/relay_checker.sv
dv/testbench.sv
